// ===== src/bu3d_pkg.sv =====
`timescale 1ns / 1ps

package bu3d_pkg;

  // command kinds carried from the front to the back
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_FETCH,
    OP_NOP
  } op_t;

  // response codes
  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_POINT     = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // back end sequencer
  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_ADV,
    B_ZPASS,
    B_XBOUND,
    B_YSTEP,
    B_YBOUND,
    B_RESPOND
  } back_state_t;

  // command queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== src/bu3d_front.sv =====
`timescale 1ns / 1ps

module bu3d_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [1:0]                   req_type,
  input  logic signed [COORD_BITS-1:0] box_min_x,
  input  logic signed [COORD_BITS-1:0] box_min_y,
  input  logic signed [COORD_BITS-1:0] box_min_z,
  input  logic signed [COORD_BITS-1:0] box_max_x,
  input  logic signed [COORD_BITS-1:0] box_max_y,
  input  logic signed [COORD_BITS-1:0] box_max_z,
  input  bu3d_pkg::q_stat_t            q_stat,
  output logic                         push,
  output logic [6*COORD_BITS+2:0]      push_data
);

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_FETCH  = 2'd2;

  bu3d_pkg::op_t op;
  logic          box_empty;

  always_comb begin
    unique case (req_type)
      REQ_CLEAR:  op = bu3d_pkg::OP_CLEAR;
      REQ_APPEND: op = bu3d_pkg::OP_APPEND;
      REQ_FETCH:  op = bu3d_pkg::OP_FETCH;
      default:    op = bu3d_pkg::OP_NOP;
    endcase
  end

  // a box that is empty on any axis never yields a point
  assign box_empty = (box_min_x >= box_max_x) || (box_min_y >= box_max_y) ||
                     (box_min_z >= box_max_z);

  assign req_ready = !q_stat.full;
  assign push      = req_valid && !q_stat.full;
  assign push_data = {op, box_empty, box_min_x, box_min_y, box_min_z,
                      box_max_x, box_max_y, box_max_z};

endmodule

// ===== src/bu3d_cmd_fifo.sv =====
`timescale 1ns / 1ps

module bu3d_cmd_fifo #(
  parameter int DATA_BITS = 99
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] pop_data,
  output bu3d_pkg::q_stat_t    q_stat
);

  localparam logic [1:0] DEPTH = 2'd2;

  logic [DATA_BITS-1:0] slot [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  assign pop_data     = slot[rd_ptr];
  assign q_stat.full  = (count == DEPTH);
  assign q_stat.empty = (count == 2'd0);

endmodule

// ===== src/bu3d_back.sv =====
`timescale 1ns / 1ps

module bu3d_back #(
  parameter int MAX_BOXES  = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bu3d_pkg::q_stat_t            q_stat,
  input  logic [6*COORD_BITS+2:0]      pop_data,
  output logic                         pop,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [1:0]                   status,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z
);

  localparam int C  = COORD_BITS;
  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int BW = 6 * COORD_BITS + 1;
  localparam int DW = BW + 2;

  // box store: {empty, lo x/y/z, hi x/y/z}
  logic [BW-1:0] mem [MAX_BOXES];
  logic [BW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;

  bu3d_pkg::back_state_t state, state_next;
  bu3d_pkg::op_t         op;

  logic [CW-1:0]        held, held_next;
  logic [IW-1:0]        walk_box, walk_box_next;
  logic signed [C-1:0]  walk_x, walk_x_next, walk_y, walk_y_next, walk_z, walk_z_next;
  logic                 walk_started, walk_started_next;
  logic                 walk_finished, walk_finished_next;

  logic signed [C-1:0]  cur_lx, cur_lz, cur_hx, cur_hy, cur_hz;
  logic signed [C-1:0]  x, x_next, y, y_next, z, z_next;
  logic signed [C-1:0]  bound, bound_next;
  logic                 zs_low, zs_low_next;
  logic                 whole_y, whole_y_next;
  logic                 moved, moved_next;
  logic [IW-1:0]        scan_addr, scan_addr_next;
  logic                 dv, dv_next;

  bu3d_pkg::status_t    res_status, res_status_next;
  logic signed [C-1:0]  res_x, res_x_next, res_y, res_y_next, res_z, res_z_next;
  logic                 rsp_load;

  logic signed [C-1:0]  e_lx, e_ly, e_lz, e_hx, e_hy, e_hz;
  logic                 e_empty;

  logic                 issue, pass_done, hit;
  logic signed [C-1:0]  nb_v, nb_lo, nb_hi, nb_r1;
  logic signed [C-1:0]  st_zi, st_xi, st_yi, st_sx, st_sy, st_sz;
  logic                 st_live;
  logic                 do_x, do_y;
  logic signed [C-1:0]  xn, yn;

  assign op = bu3d_pkg::op_t'(pop_data[DW-1:DW-2]);

  assign e_empty = rd_data[6*C];
  assign e_lx    = rd_data[6*C-1:5*C];
  assign e_ly    = rd_data[5*C-1:4*C];
  assign e_lz    = rd_data[4*C-1:3*C];
  assign e_hx    = rd_data[3*C-1:2*C];
  assign e_hy    = rd_data[2*C-1:C];
  assign e_hz    = rd_data[C-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[held[IW-1:0]] <= pop_data[BW-1:0];
    rd_data <= mem[rd_addr];
  end

  // scan over the boxes below walk_box, one read per cycle, read data registered
  assign issue = ((state == bu3d_pkg::B_ZPASS) || (state == bu3d_pkg::B_XBOUND) ||
                  (state == bu3d_pkg::B_YBOUND)) && (scan_addr != walk_box);
  assign pass_done = !issue && !dv;

  assign hit = dv && (x >= e_lx) && (x < e_hx) && (y >= e_ly) && (y < e_hy) &&
               (z >= e_lz) && (z < e_hz);

  // next corner above v among earlier boxes, capped by bound
  always_comb begin
    if (state == bu3d_pkg::B_XBOUND) begin
      nb_v  = x;
      nb_lo = e_lx;
      nb_hi = e_hx;
    end else begin
      nb_v  = y;
      nb_lo = e_ly;
      nb_hi = e_hy;
    end
    nb_r1 = ((nb_lo > nb_v) && (nb_lo < bound)) ? nb_lo : bound;
  end

  // resume point inside the box just read
  always_comb begin
    st_zi = walk_z + C'(1);
    st_xi = walk_x + C'(1);
    st_yi = walk_y + C'(1);
    if (!walk_started) begin
      st_sx   = e_lx;
      st_sy   = e_ly;
      st_sz   = e_lz;
      st_live = !e_empty;
    end else if (st_zi < e_hz) begin
      st_sx   = walk_x;
      st_sy   = walk_y;
      st_sz   = st_zi;
      st_live = 1'b1;
    end else if (st_xi < e_hx) begin
      st_sx   = st_xi;
      st_sy   = walk_y;
      st_sz   = e_lz;
      st_live = 1'b1;
    end else begin
      st_sx   = e_lx;
      st_sy   = st_yi;
      st_sz   = e_lz;
      st_live = (st_yi < e_hy);
    end
  end

  always_comb begin
    state_next         = state;
    held_next          = held;
    walk_box_next      = walk_box;
    walk_x_next        = walk_x;
    walk_y_next        = walk_y;
    walk_z_next        = walk_z;
    walk_started_next  = walk_started;
    walk_finished_next = walk_finished;
    x_next             = x;
    y_next             = y;
    z_next             = z;
    bound_next         = bound;
    zs_low_next        = zs_low;
    whole_y_next       = whole_y;
    moved_next         = moved;
    scan_addr_next     = issue ? (scan_addr + IW'(1)) : scan_addr;
    dv_next            = issue;
    res_status_next    = res_status;
    res_x_next         = res_x;
    res_y_next         = res_y;
    res_z_next         = res_z;
    rd_addr            = scan_addr;
    wr_en              = 1'b0;
    pop                = 1'b0;
    do_x               = 1'b0;
    do_y               = 1'b0;
    xn                 = x + C'(1);
    yn                 = y + C'(1);

    unique case (state)
      bu3d_pkg::B_IDLE: begin
        res_x_next = '0;
        res_y_next = '0;
        res_z_next = '0;
        res_status_next = bu3d_pkg::ST_ACCEPTED;
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = bu3d_pkg::B_RESPOND;
          unique case (op)
            bu3d_pkg::OP_CLEAR: begin
              held_next          = '0;
              walk_box_next      = '0;
              walk_x_next        = '0;
              walk_y_next        = '0;
              walk_z_next        = '0;
              walk_started_next  = 1'b0;
              walk_finished_next = 1'b0;
            end
            bu3d_pkg::OP_APPEND: begin
              if (held == CW'(MAX_BOXES)) begin
                res_status_next = bu3d_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                held_next = held + CW'(1);
              end
            end
            bu3d_pkg::OP_FETCH: begin
              if ((held == '0) || walk_finished) begin
                res_status_next = bu3d_pkg::ST_EXHAUSTED;
              end else begin
                rd_addr    = walk_box;
                state_next = bu3d_pkg::B_LOAD;
              end
            end
            bu3d_pkg::OP_NOP: begin
            end
          endcase
        end
      end

      bu3d_pkg::B_LOAD: begin
        if (!st_live) begin
          state_next = bu3d_pkg::B_ADV;
        end else begin
          x_next         = st_sx;
          y_next         = st_sy;
          z_next         = st_sz;
          zs_low_next    = (st_sz == e_lz);
          whole_y_next   = (st_sx == e_lx) && (st_sz == e_lz);
          moved_next     = 1'b0;
          scan_addr_next = '0;
          dv_next        = 1'b0;
          state_next     = bu3d_pkg::B_ZPASS;
        end
      end

      bu3d_pkg::B_ADV: begin
        walk_started_next = 1'b0;
        if ((CW'(walk_box) + CW'(1)) >= held) begin
          walk_finished_next = 1'b1;
          res_status_next    = bu3d_pkg::ST_EXHAUSTED;
          state_next         = bu3d_pkg::B_RESPOND;
        end else begin
          walk_box_next = walk_box + IW'(1);
          rd_addr       = walk_box + IW'(1);
          state_next    = bu3d_pkg::B_LOAD;
        end
      end

      bu3d_pkg::B_ZPASS: begin
        if (z >= cur_hz) begin
          // row has no free point left
          if (zs_low) begin
            bound_next     = cur_hx;
            scan_addr_next = '0;
            dv_next        = 1'b0;
            state_next     = bu3d_pkg::B_XBOUND;
          end else begin
            do_x = 1'b1;
          end
        end else if (pass_done) begin
          if (moved) begin
            moved_next     = 1'b0;
            scan_addr_next = '0;
            dv_next        = 1'b0;
          end else begin
            walk_x_next       = x;
            walk_y_next       = y;
            walk_z_next       = z;
            walk_started_next = 1'b1;
            res_status_next   = bu3d_pkg::ST_POINT;
            res_x_next        = x;
            res_y_next        = y;
            res_z_next        = z;
            state_next        = bu3d_pkg::B_RESPOND;
          end
        end else if (hit) begin
          z_next     = e_hz;
          moved_next = 1'b1;
        end
      end

      bu3d_pkg::B_XBOUND: begin
        if (dv) bound_next = ((nb_hi > nb_v) && (nb_hi < nb_r1)) ? nb_hi : nb_r1;
        if (pass_done) begin
          xn   = bound;
          do_x = 1'b1;
        end
      end

      bu3d_pkg::B_YSTEP: begin
        if (whole_y) begin
          bound_next     = cur_hy;
          scan_addr_next = '0;
          dv_next        = 1'b0;
          state_next     = bu3d_pkg::B_YBOUND;
        end else begin
          do_y = 1'b1;
        end
      end

      bu3d_pkg::B_YBOUND: begin
        if (dv) bound_next = ((nb_hi > nb_v) && (nb_hi < nb_r1)) ? nb_hi : nb_r1;
        if (pass_done) begin
          yn   = bound;
          do_y = 1'b1;
        end
      end

      bu3d_pkg::B_RESPOND: begin
        if (rsp_load) state_next = bu3d_pkg::B_IDLE;
      end
    endcase

    // step to the next row of x
    if (do_x) begin
      if (xn < cur_hx) begin
        x_next         = xn;
        z_next         = cur_lz;
        zs_low_next    = 1'b1;
        moved_next     = 1'b0;
        scan_addr_next = '0;
        dv_next        = 1'b0;
        state_next     = bu3d_pkg::B_ZPASS;
      end else begin
        state_next = bu3d_pkg::B_YSTEP;
      end
    end

    // step to the next plane of y
    if (do_y) begin
      if (yn < cur_hy) begin
        y_next         = yn;
        x_next         = cur_lx;
        z_next         = cur_lz;
        zs_low_next    = 1'b1;
        whole_y_next   = 1'b1;
        moved_next     = 1'b0;
        scan_addr_next = '0;
        dv_next        = 1'b0;
        state_next     = bu3d_pkg::B_ZPASS;
      end else begin
        state_next = bu3d_pkg::B_ADV;
      end
    end
  end

  assign rsp_load = (state == bu3d_pkg::B_RESPOND) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bu3d_pkg::B_IDLE;
      held          <= '0;
      walk_box      <= '0;
      walk_x        <= '0;
      walk_y        <= '0;
      walk_z        <= '0;
      walk_started  <= 1'b0;
      walk_finished <= 1'b0;
      scan_addr     <= '0;
      dv            <= 1'b0;
      moved         <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      held          <= held_next;
      walk_box      <= walk_box_next;
      walk_x        <= walk_x_next;
      walk_y        <= walk_y_next;
      walk_z        <= walk_z_next;
      walk_started  <= walk_started_next;
      walk_finished <= walk_finished_next;
      scan_addr     <= scan_addr_next;
      dv            <= dv_next;
      moved         <= moved_next;
      if (rsp_load)       rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    x          <= x_next;
    y          <= y_next;
    z          <= z_next;
    bound      <= bound_next;
    zs_low     <= zs_low_next;
    whole_y    <= whole_y_next;
    res_status <= res_status_next;
    res_x      <= res_x_next;
    res_y      <= res_y_next;
    res_z      <= res_z_next;
    if (state == bu3d_pkg::B_LOAD) begin
      cur_lx <= e_lx;
      cur_lz <= e_lz;
      cur_hx <= e_hx;
      cur_hy <= e_hy;
      cur_hz <= e_hz;
    end
    if (rsp_load) begin
      status  <= res_status;
      point_x <= res_x;
      point_y <= res_y;
      point_z <= res_z;
    end
  end

endmodule

// ===== src/box_union_unique_point_walker_3d_top.sv =====
`timescale 1ns / 1ps

// Box union point walker. Requests arrive on req_valid/req_ready with req_type
// (clear, append box, fetch next point) and the six box corner fields; each
// request item gives exactly one response item on rsp_valid/rsp_ready carrying
// status and the point coordinates (zero unless a point is given).
// Clear, append and ignored codes go from idle straight to the respond state.
// A fetch loads each box it enters and moves on past each box it leaves. Inside
// a box each pass scans the b earlier boxes through the single read port of
// the box store, one box per cycle; a row of z takes at most one pass plus one
// more for each pass that moved z, and each jump over covered x rows or y
// planes takes one more pass.
// A two-entry request queue sits between the front decoder and the back
// sequencer, so up to two items are taken while the back is busy or while a
// finished response waits in the output register for rsp_ready.
// Reset (rst, synchronous) empties the list, rewinds the walk, flushes the
// queue and drops rsp_valid; the box store itself is not cleared.

module box_union_unique_point_walker_3d_top #(
  parameter int MAX_BOXES  = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [1:0]                   req_type,
  input  logic signed [COORD_BITS-1:0] box_min_x,
  input  logic signed [COORD_BITS-1:0] box_min_y,
  input  logic signed [COORD_BITS-1:0] box_min_z,
  input  logic signed [COORD_BITS-1:0] box_max_x,
  input  logic signed [COORD_BITS-1:0] box_max_y,
  input  logic signed [COORD_BITS-1:0] box_max_z,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [1:0]                   status,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z
);

  // queue word: op, empty flag, six corners
  localparam int DW = 6 * COORD_BITS + 3;

  bu3d_pkg::q_stat_t q_stat;
  logic              push;
  logic [DW-1:0]     push_data;
  logic              pop;
  logic [DW-1:0]     pop_data;

  // front: decode request and flag empty boxes
  bu3d_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_type  (req_type),
    .box_min_x (box_min_x),
    .box_min_y (box_min_y),
    .box_min_z (box_min_z),
    .box_max_x (box_max_x),
    .box_max_y (box_max_y),
    .box_max_z (box_max_z),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // short queue decoupling the two sides
  bu3d_cmd_fifo #(
    .DATA_BITS(DW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // back: box store, walk state, point search and output register
  bu3d_back #(
    .MAX_BOXES (MAX_BOXES),
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z)
  );

endmodule

// ===== src/bu3d_checker.sv =====
`timescale 1ns / 1ps

module bu3d_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [1:0]                   status,
  input logic signed [COORD_BITS-1:0] point_x,
  input logic signed [COORD_BITS-1:0] point_y,
  input logic signed [COORD_BITS-1:0] point_z
);

  // items taken but not yet answered
  logic [2:0] pending;
  logic       acc_in, acc_out;

  assign acc_in  = req_valid && req_ready;
  assign acc_out = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else if (acc_in && !acc_out) begin
      pending <= pending + 3'd1;
    end else if (acc_out && !acc_in) begin
      pending <= pending - 3'd1;
    end
  end

  a_idle_after_reset: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(point_x) &&
      $stable(point_y) && $stable(point_z))
    else $error("stalled response changed");

  a_zero_point: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != bu3d_pkg::ST_POINT) |->
      (point_x == '0) && (point_y == '0) && (point_z == '0))
    else $error("nonzero point without a point status");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (pending != 3'd0))
    else $error("response without an outstanding item");

endmodule

bind box_union_unique_point_walker_3d_top bu3d_checker #(
  .COORD_BITS(COORD_BITS)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .status    (status),
  .point_x   (point_x),
  .point_y   (point_y),
  .point_z   (point_z)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int MAXB          = 16;
  localparam int CB            = 16;
  localparam int IDLE_LIMIT    = 100000;  // cycles with no item moving on either side
  localparam int SETTLE_CYCLES = 200;
  localparam int QUIET_TAIL    = 100;     // last items run with no idling
  localparam int HOLD_AFTER    = 300;     // responses seen before the long hold-off
  localparam int HOLD_CYCLES   = 150;

  // one request item as driven on the pins
  typedef struct packed {
    bu3d_pkg::op_t kind;
    logic [CB-1:0] lo_x, lo_y, lo_z;
    logic [CB-1:0] hi_x, hi_y, hi_z;
  } box_req_t;

  // one predicted response item
  typedef struct packed {
    bu3d_pkg::status_t st;
    logic [CB-1:0]     px, py, pz;
  } walk_rsp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  logic [1:0]           req_type = bu3d_pkg::OP_NOP;
  logic signed [CB-1:0] box_min_x = '0;
  logic signed [CB-1:0] box_min_y = '0;
  logic signed [CB-1:0] box_min_z = '0;
  logic signed [CB-1:0] box_max_x = '0;
  logic signed [CB-1:0] box_max_y = '0;
  logic signed [CB-1:0] box_max_z = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  logic [1:0]           status;
  logic signed [CB-1:0] point_x;
  logic signed [CB-1:0] point_y;
  logic signed [CB-1:0] point_z;

  box_req_t  pending_reqs [$];   // stimulus not yet offered
  walk_rsp_t walk_expect [$];    // predicted responses in order
  box_req_t  offered_req;        // item currently on the request pins

  logic req_taken = 1'b0;        // request handshake at the last rising edge
  int   send_gap = 0;
  int   drain_gap = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   quiet_cycles = 0;
  int   fail_count = 0;
  int   rsp_count = 0;
  int   points_seen = 0;
  int   exhausted_seen = 0;
  int   dropped_seen = 0;
  int   items_total = 0;

  // predictor copy of the box list and the walk position
  longint corner_lo [MAXB][3];
  longint corner_hi [MAXB][3];
  int     held_boxes = 0;
  int     cur_box = 0;
  longint cur_x = 0, cur_y = 0, cur_z = 0;
  bit     cur_started = 1'b0;
  bit     cur_done = 1'b0;

  box_union_unique_point_walker_3d_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_type  (req_type),
    .box_min_x (box_min_x),
    .box_min_y (box_min_y),
    .box_min_z (box_min_z),
    .box_max_x (box_max_x),
    .box_max_y (box_max_y),
    .box_max_z (box_max_z),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // nearest corner of the earlier boxes above v on one axis, capped
  function automatic longint corner_above(int axis, int upto, longint v, longint cap);
    longint r = cap;
    for (int i = 0; i < upto; i++) begin
      if (corner_lo[i][axis] > v && corner_lo[i][axis] < r) r = corner_lo[i][axis];
      if (corner_hi[i][axis] > v && corner_hi[i][axis] < r) r = corner_hi[i][axis];
    end
    return r;
  endfunction

  // first z on row (x, y) at or past z0 that no earlier box covers
  function automatic longint skip_covered_z(int upto, longint x, longint y, longint z0,
                                            longint zmax);
    longint z = z0;
    bit moved = 1'b1;
    while (moved && z < zmax) begin
      moved = 1'b0;
      for (int i = 0; i < upto; i++) begin
        if (x >= corner_lo[i][0] && x < corner_hi[i][0] &&
            y >= corner_lo[i][1] && y < corner_hi[i][1] &&
            z >= corner_lo[i][2] && z < corner_hi[i][2]) begin
          z = corner_hi[i][2];
          moved = 1'b1;
        end
      end
    end
    return z;
  endfunction

  // first uncovered point of box b at or after (sy, sx, sz) in walk order
  function automatic bit first_open_point(int b, longint sy, longint sx, longint sz,
                                          output longint px, output longint py,
                                          output longint pz);
    longint y = sy;
    longint x, zs, z;
    bit first_y = 1'b1;
    bit first_x, whole_y;
    px = 0;
    py = 0;
    pz = 0;
    while (y < corner_hi[b][1]) begin
      x = first_y ? sx : corner_lo[b][0];
      // a plane entered at its very start may jump to the next y corner
      whole_y = !first_y || (sx == corner_lo[b][0] && sz == corner_lo[b][2]);
      first_x = first_y;
      while (x < corner_hi[b][0]) begin
        zs = first_x ? sz : corner_lo[b][2];
        z = skip_covered_z(b, x, y, zs, corner_hi[b][2]);
        if (z < corner_hi[b][2]) begin
          px = x;
          py = y;
          pz = z;
          return 1'b1;
        end
        x = (zs == corner_lo[b][2]) ? corner_above(0, b, x, corner_hi[b][0]) : x + 1;
        first_x = 1'b0;
      end
      y = whole_y ? corner_above(1, b, y, corner_hi[b][1]) : y + 1;
      first_y = 1'b0;
    end
    return 1'b0;
  endfunction

  // next point of the union, moving on through the list as boxes run dry
  function automatic bu3d_pkg::status_t walk_fetch(output longint px, output longint py,
                                                   output longint pz);
    longint sx, sy, sz;
    bit live;
    px = 0;
    py = 0;
    pz = 0;
    if (held_boxes == 0 || cur_done) return bu3d_pkg::ST_EXHAUSTED;
    while (1'b1) begin
      live = 1'b1;
      if (!cur_started) begin
        sx = corner_lo[cur_box][0];
        sy = corner_lo[cur_box][1];
        sz = corner_lo[cur_box][2];
        // empty on any axis gives nothing
        if (sx >= corner_hi[cur_box][0] || sy >= corner_hi[cur_box][1] ||
            sz >= corner_hi[cur_box][2])
          live = 1'b0;
      end else begin
        sx = cur_x;
        sy = cur_y;
        sz = cur_z + 1;
        if (sz >= corner_hi[cur_box][2]) begin
          sz = corner_lo[cur_box][2];
          sx++;
          if (sx >= corner_hi[cur_box][0]) begin
            sx = corner_lo[cur_box][0];
            sy++;
            if (sy >= corner_hi[cur_box][1]) live = 1'b0;
          end
        end
      end
      if (live && first_open_point(cur_box, sy, sx, sz, px, py, pz)) begin
        cur_x = px;
        cur_y = py;
        cur_z = pz;
        cur_started = 1'b1;
        return bu3d_pkg::ST_POINT;
      end
      cur_started = 1'b0;
      cur_box++;
      if (cur_box >= held_boxes) begin
        cur_done = 1'b1;
        return bu3d_pkg::ST_EXHAUSTED;
      end
    end
    return bu3d_pkg::ST_EXHAUSTED;
  endfunction

  function automatic walk_rsp_t predict_walk(box_req_t r);
    walk_rsp_t e;
    longint px, py, pz;
    e = '{st: bu3d_pkg::ST_ACCEPTED, px: '0, py: '0, pz: '0};
    case (r.kind)
      bu3d_pkg::OP_CLEAR: begin
        held_boxes = 0;
        cur_box = 0;
        cur_x = 0;
        cur_y = 0;
        cur_z = 0;
        cur_started = 1'b0;
        cur_done = 1'b0;
      end
      bu3d_pkg::OP_APPEND: begin
        if (held_boxes >= MAXB) begin
          e.st = bu3d_pkg::ST_FULL;
        end else begin
          corner_lo[held_boxes][0] = $signed(r.lo_x);
          corner_lo[held_boxes][1] = $signed(r.lo_y);
          corner_lo[held_boxes][2] = $signed(r.lo_z);
          corner_hi[held_boxes][0] = $signed(r.hi_x);
          corner_hi[held_boxes][1] = $signed(r.hi_y);
          corner_hi[held_boxes][2] = $signed(r.hi_z);
          held_boxes++;
        end
      end
      bu3d_pkg::OP_FETCH: begin
        e.st = walk_fetch(px, py, pz);
        if (e.st == bu3d_pkg::ST_POINT) begin
          e.px = px[CB-1:0];
          e.py = py[CB-1:0];
          e.pz = pz[CB-1:0];
        end
      end
      default: ;  // unused code, plain acknowledge
    endcase
    return e;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic longint rand_coord();
    return longint'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic box_req_t box_item(longint lx, longint ly, longint lz,
                                        longint hx, longint hy, longint hz);
    box_req_t r;
    r.kind = bu3d_pkg::OP_APPEND;
    r.lo_x = lx[CB-1:0];
    r.lo_y = ly[CB-1:0];
    r.lo_z = lz[CB-1:0];
    r.hi_x = hx[CB-1:0];
    r.hi_y = hy[CB-1:0];
    r.hi_z = hz[CB-1:0];
    return r;
  endfunction

  // non-append items carry junk corners, which the block must ignore
  function automatic box_req_t op_item(bu3d_pkg::op_t k);
    box_req_t r;
    r = box_item(rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord());
    r.kind = k;
    return r;
  endfunction

  function automatic box_req_t wide_box();
    return box_item(rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord());
  endfunction

  // cluster corner: range ends now and then, so walks hit both coordinate limits
  function automatic longint pick_origin();
    case ($urandom_range(0, 7))
      0:       return -32768;
      1:       return 32767 - 8;
      default: return longint'($urandom_range(0, 65535 - 8)) - 32768;
    endcase
  endfunction

  // usually a clear, then a cluster of overlapping small boxes walked mostly to the end,
  // with fetches mixed into the appends and some noise items
  task automatic add_scene();
    longint org [3];
    longint lo [3];
    longint hi [3];
    longint vol, vol_sum;
    int n_box, n_fetch;
    bit wide;
    if ($urandom_range(0, 7) != 0) pending_reqs.push_back(op_item(bu3d_pkg::OP_CLEAR));
    n_box = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 5);
    for (int a = 0; a < 3; a++) org[a] = pick_origin();
    vol_sum = 0;
    wide = 1'b0;
    for (int k = 0; k < n_box; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        pending_reqs.push_back(wide_box());
        wide = 1'b1;
      end else begin
        vol = 1;
        for (int a = 0; a < 3; a++) begin
          lo[a] = org[a] + $urandom_range(0, 5);
          case ($urandom_range(0, 11))
            0: hi[a] = lo[a];
            1: begin
              // min above max
              hi[a] = lo[a] - $urandom_range(1, 3);
              if (hi[a] < -32768) hi[a] = -32768;
            end
            default: hi[a] = lo[a] + $urandom_range(1, 3);
          endcase
          vol = (hi[a] > lo[a]) ? vol * (hi[a] - lo[a]) : 0;
        end
        vol_sum += vol;
        pending_reqs.push_back(box_item(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]));
      end
      // fetch while later boxes are still arriving
      if (k > 0 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) pending_reqs.push_back(op_item(bu3d_pkg::OP_FETCH));
      if ($urandom_range(0, 15) == 0) pending_reqs.push_back(op_item(bu3d_pkg::OP_NOP));
    end
    // volume sum bounds the union, so this runs the walk out when it is small
    n_fetch = (!wide && vol_sum + 2 <= 80) ? int'(vol_sum) + 2 : $urandom_range(10, 40);
    repeat (n_fetch) pending_reqs.push_back(op_item(bu3d_pkg::OP_FETCH));
  endtask

  function automatic bit calm_window();
    return pending_reqs.size() < QUIET_TAIL ||
           (pending_reqs.size() >= 500 && pending_reqs.size() < 560);
  endfunction

  // ---------------------------------------------------------------- request side

  // new item only once the last one was taken; gaps are bursts of idle cycles
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        offered_req = pending_reqs.pop_front();
        req_type  <= offered_req.kind;
        box_min_x <= offered_req.lo_x;
        box_min_y <= offered_req.lo_y;
        box_min_z <= offered_req.lo_z;
        box_max_x <= offered_req.hi_x;
        box_max_y <= offered_req.hi_y;
        box_max_z <= offered_req.hi_z;
        req_valid <= 1'b1;
        if (!calm_window() && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 11);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- response side

  // one long hold-off fills the request queue and stalls the input,
  // otherwise random stall bursts outside the calm stretches
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (!hold_done && rsp_count >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      rsp_ready <= 1'b0;
    end else if (drain_gap > 0) begin
      drain_gap <= drain_gap - 1;
      rsp_ready <= 1'b0;
    end else if (!calm_window() && $urandom_range(0, 7) == 0) begin
      drain_gap <= $urandom_range(0, 10);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  task automatic check_coord(string axis, logic [CB-1:0] want, logic [CB-1:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d, got %0d", $time, axis,
               $signed(want), $signed(got));
      fail_count++;
    end
  endtask

  // scoreboard: predict on request accept, compare on response accept
  always @(posedge clk) begin
    walk_rsp_t want;
    req_taken <= req_valid && req_ready && !rst;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        rsp_count++;
        if (walk_expect.size() == 0) begin
          $display("%0t response with nothing pending: status %0d point %0d %0d %0d",
                   $time, status, point_x, point_y, point_z);
          fail_count++;
        end else begin
          want = walk_expect.pop_front();
          if (status !== want.st) begin
            $display("%0t status mismatch: expected %0d, got %0d", $time, want.st, status);
            fail_count++;
          end
          check_coord("point_x", want.px, point_x);
          check_coord("point_y", want.py, point_y);
          check_coord("point_z", want.pz, point_z);
          case (want.st)
            bu3d_pkg::ST_POINT:     points_seen++;
            bu3d_pkg::ST_EXHAUSTED: exhausted_seen++;
            bu3d_pkg::ST_FULL:      dropped_seen++;
            default: ;
          endcase
        end
      end
      if (req_valid && req_ready) walk_expect.push_back(predict_walk(offered_req));
    end
  end

  // watchdog on cycles where no item moves
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t no handshake for %0d cycles, %0d items queued, %0d responses owed",
               $time, IDLE_LIMIT, pending_reqs.size(), walk_expect.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- run

  initial begin
    // directed: empty list, unused code, corner extremes, empty and inverted boxes
    pending_reqs.push_back(op_item(bu3d_pkg::OP_FETCH));
    pending_reqs.push_back(op_item(bu3d_pkg::OP_NOP));
    pending_reqs.push_back(box_item(-32768, 32766, -32768, -32767, 32767, -32767));
    pending_reqs.push_back(box_item(0, 0, 5, 2, 2, 5));
    pending_reqs.push_back(box_item(5, 0, 0, -5, 2, 2));
    pending_reqs.push_back(box_item(-1, -1, 0, 1, 1, 1));
    repeat (2) pending_reqs.push_back(op_item(bu3d_pkg::OP_FETCH));
    // append mid-walk, overlapping the box being walked at the origin
    pending_reqs.push_back(box_item(0, 0, 0, 2, 1, 1));
    repeat (5) pending_reqs.push_back(op_item(bu3d_pkg::OP_FETCH));
    // appended after the walk ran out, so never walked before a clear
    pending_reqs.push_back(box_item(10, 10, 10, 11, 11, 11));
    pending_reqs.push_back(op_item(bu3d_pkg::OP_FETCH));
    // fill the list, then one more append is dropped
    repeat (10) pending_reqs.push_back(wide_box());
    pending_reqs.push_back(wide_box());
    pending_reqs.push_back(op_item(bu3d_pkg::OP_CLEAR));

    while (pending_reqs.size() < 1000) add_scene();
    items_total = pending_reqs.size();

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid || walk_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d request items, %0d responses checked", items_total, rsp_count);
    $display("%0d points walked, %0d exhausted answers, %0d appends dropped on a full list",
             points_seen, exhausted_seen, dropped_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
